@@ hdl/esmc_pkg.sv @@
// Shared types, codes and widths for the event/semaphore/mutex counter.
package esmc_pkg;

   localparam int CMD_W     = 4;
   localparam int VALUE_W   = 64;
   localparam int CALLER_W  = 22;
   localparam int STATUS_W  = 2;
   localparam int MODE_W    = 2;
   localparam int WAKE_W    = 2;

   localparam int OWNER_ID_BITS_DEF = 22;

   localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_READ     = 4'd0,
      CMD_WRITE    = 4'd1,
      CMD_POLL     = 4'd2,
      CMD_FLUSH    = 4'd3,
      CMD_WAITREAD = 4'd4,
      CMD_SEM      = 4'd5,
      CMD_MUTEX    = 4'd6,
      CMD_EVENT    = 4'd7,
      CMD_SETMAX   = 4'd8,
      CMD_SETERROR = 4'd9,
      CMD_GETMODE  = 4'd10
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_EVENT = 2'd0,
      MODE_SEM   = 2'd1,
      MODE_MUTEX = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_INVAL = 2'd1,
      ST_AGAIN = 2'd2,
      ST_PERM  = 2'd3
   } status_type;

   typedef enum logic [WAKE_W-1:0] {
      WAKE_NONE  = 2'd0,
      WAKE_READ  = 2'd1,
      WAKE_ERROR = 2'd2
   } wake_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [VALUE_W-1:0]  value;
      logic [CALLER_W-1:0] caller_pid;
      logic [CALLER_W-1:0] caller_tid;
      logic                waiters_present;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  result_value;
      logic                readable;
      logic                error_flag;
      logic [WAKE_W-1:0]   wake_kind;
   } rsp_type;

endpackage

@@ hdl/esmc_req_if.sv @@
// Command channel: valid/ready handshake with the command payload.
interface esmc_req_if import esmc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [VALUE_W-1:0]  value;
   logic [CALLER_W-1:0] caller_pid;
   logic [CALLER_W-1:0] caller_tid;
   logic                waiters_present;

   modport source (
      output valid, cmd, value, caller_pid, caller_tid, waiters_present,
      input  ready
   );
   modport sink (
      input  valid, cmd, value, caller_pid, caller_tid, waiters_present,
      output ready
   );
endinterface

@@ hdl/esmc_rsp_if.sv @@
// Result channel: valid/ready handshake with the result payload.
interface esmc_rsp_if import esmc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  result_value;
   logic                readable;
   logic                error_flag;
   logic [WAKE_W-1:0]   wake_kind;

   modport source (
      output valid, status, result_value, readable, error_flag, wake_kind,
      input  ready
   );
   modport sink (
      input  valid, status, result_value, readable, error_flag, wake_kind,
      output ready
   );
endinterface

@@ hdl/esmc_core.sv @@
// Counter state and the combinational command evaluation.
module esmc_core import esmc_pkg::*; #(
   parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic [VALUE_W-1:0]       counter_ff,   counter_in;
   mode_type                 mode_ff,      mode_in;
   logic                     error_set_ff, error_set_in;
   logic                     wait_read_ff, wait_read_in;
   logic [VALUE_W-1:0]       max_count_ff, max_count_in;
   logic [OWNER_ID_BITS-1:0] owner_pid_ff, owner_pid_in;
   logic [OWNER_ID_BITS-1:0] owner_tid_ff, owner_tid_in;

   logic [OWNER_ID_BITS-1:0] pid_m;
   logic [OWNER_ID_BITS-1:0] tid_m;

   // keep only the identifier bits that ownership uses
   if (OWNER_ID_BITS <= CALLER_W) begin : g_id_trunc
      assign pid_m = req.caller_pid[OWNER_ID_BITS-1:0];
      assign tid_m = req.caller_tid[OWNER_ID_BITS-1:0];
   end else begin : g_id_ext
      assign pid_m = {{(OWNER_ID_BITS-CALLER_W){1'b0}}, req.caller_pid};
      assign tid_m = {{(OWNER_ID_BITS-CALLER_W){1'b0}}, req.caller_tid};
   end

   logic               is_owner;
   logic               cnt_zero;
   logic [VALUE_W-1:0] take_got;
   logic [VALUE_W-1:0] take_cnt;
   logic               take_own;
   logic [VALUE_W-1:0] sem_room;

   assign is_owner = (owner_pid_ff == pid_m) && (owner_tid_ff == tid_m);
   assign cnt_zero = (counter_ff == '0);
   assign sem_room = max_count_ff - counter_ff;

   // consume per mode; take_own marks a fresh mutex lock
   always_comb begin
      take_got = '0;
      take_cnt = counter_ff;
      take_own = 1'b0;
      unique case (mode_ff)
         MODE_SEM: begin
            if (!cnt_zero) begin
               take_got = {{(VALUE_W-1){1'b0}}, 1'b1};
               take_cnt = counter_ff - {{(VALUE_W-1){1'b0}}, 1'b1};
            end
         end
         MODE_MUTEX: begin
            if (cnt_zero) begin
               take_got = {{(VALUE_W-1){1'b0}}, 1'b1};
               take_cnt = {{(VALUE_W-1){1'b0}}, 1'b1};
               take_own = 1'b1;
            end else if (is_owner && counter_ff != ALL_ONES) begin
               take_got = {{(VALUE_W-1){1'b0}}, 1'b1};
               take_cnt = counter_ff + {{(VALUE_W-1){1'b0}}, 1'b1};
            end
         end
         default: begin
            take_got = counter_ff;
            take_cnt = '0;
         end
      endcase
   end

   always_comb begin
      counter_in   = counter_ff;
      mode_in      = mode_ff;
      error_set_in = error_set_ff;
      wait_read_in = wait_read_ff;
      max_count_in = max_count_ff;
      owner_pid_in = owner_pid_ff;
      owner_tid_in = owner_tid_ff;
      rsp          = '0;
      rsp.status   = ST_OK;
      rsp.wake_kind = WAKE_NONE;

      unique case (req.cmd)
         CMD_READ: begin
            counter_in = take_cnt;
            if (take_own) begin
               owner_pid_in = pid_m;
               owner_tid_in = tid_m;
            end
            if (take_got == '0) rsp.status = ST_AGAIN;
            else rsp.result_value = take_got;
         end
         CMD_WRITE: begin
            priority if (req.value == ALL_ONES) begin
               rsp.status = ST_INVAL;
            end else if (mode_ff == MODE_SEM) begin
               if (counter_ff > max_count_ff || req.value > sem_room)
                  rsp.status = ST_INVAL;
               else
                  counter_in = counter_ff + req.value;
            end else if (mode_ff == MODE_MUTEX) begin
               if (req.value <= counter_ff && is_owner)
                  counter_in = counter_ff - req.value;
               else
                  rsp.status = ST_PERM;
            end else begin
               counter_in = counter_ff + req.value;
            end
            if (rsp.status == ST_OK && req.waiters_present) rsp.wake_kind = WAKE_READ;
         end
         CMD_POLL: begin
            priority if (error_set_ff) begin
               rsp.error_flag = 1'b1;
            end else if (wait_read_ff) begin
               // poll consumes in this mode
               counter_in = take_cnt;
               if (take_own) begin
                  owner_pid_in = pid_m;
                  owner_tid_in = tid_m;
               end
               rsp.readable = (take_got != '0);
            end else if (mode_ff == MODE_MUTEX) begin
               rsp.readable = cnt_zero;
            end else begin
               rsp.readable = !cnt_zero;
            end
         end
         CMD_FLUSH: begin
            if (mode_ff == MODE_MUTEX && is_owner) begin
               counter_in   = '0;
               error_set_in = 1'b1;
               if (req.waiters_present) rsp.wake_kind = WAKE_ERROR;
            end
         end
         CMD_WAITREAD: begin
            if (req.waiters_present) rsp.status = ST_INVAL;
            else wait_read_in = (req.value != '0);
         end
         CMD_SEM: begin
            if (req.waiters_present) begin
               rsp.status = ST_INVAL;
            end else begin
               mode_in      = MODE_SEM;
               counter_in   = req.value;
               max_count_in = ALL_ONES;
            end
         end
         CMD_MUTEX: begin
            if (req.waiters_present) begin
               rsp.status = ST_INVAL;
            end else begin
               mode_in    = MODE_MUTEX;
               counter_in = req.value;
               if (req.value != '0) begin
                  owner_pid_in = pid_m;
                  owner_tid_in = tid_m;
               end else begin
                  owner_pid_in = '0;
                  owner_tid_in = '0;
               end
            end
         end
         CMD_EVENT: begin
            if (req.waiters_present) begin
               rsp.status = ST_INVAL;
            end else begin
               mode_in    = MODE_EVENT;
               counter_in = req.value;
            end
         end
         CMD_SETMAX: begin
            if (counter_ff <= req.value && mode_ff == MODE_SEM) max_count_in = req.value;
            else rsp.status = ST_INVAL;
         end
         CMD_SETERROR: begin
            error_set_in = (req.value != '0);
            if (req.value != '0 && req.waiters_present) rsp.wake_kind = WAKE_ERROR;
         end
         CMD_GETMODE: begin
            rsp.result_value = {{(VALUE_W-MODE_W){1'b0}}, mode_ff};
         end
         default: begin
            rsp.status = ST_INVAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         mode_ff      <= MODE_EVENT;
         error_set_ff <= 1'b0;
         wait_read_ff <= 1'b0;
         max_count_ff <= ALL_ONES;
         owner_pid_ff <= '0;
         owner_tid_ff <= '0;
      end else if (fire) begin
         counter_ff   <= counter_in;
         mode_ff      <= mode_in;
         error_set_ff <= error_set_in;
         wait_read_ff <= wait_read_in;
         max_count_ff <= max_count_in;
         owner_pid_ff <= owner_pid_in;
         owner_tid_ff <= owner_tid_in;
      end
   end

endmodule

@@ hdl/event_semaphore_mutex_counter.sv @@
// Throughput: one command per cycle while the result side is ready; the input
// register, the state update and the result register each take one beat per
// clock with no loop over cycles.
// Reset (synchronous, active high): both stages empty, counter 0, event mode,
// error and waitread clear, maximum all ones, owner identifiers 0.
module event_semaphore_mutex_counter import esmc_pkg::*; #(
   parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   esmc_req_if.sink   req_if,
   esmc_rsp_if.source rsp_if
);

   logic    in_valid_ff,  in_valid_in;
   req_type in_req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    advance;

   // move the held command into the result stage when that stage frees up
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;

   assign in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   esmc_core #(
      .OWNER_ID_BITS(OWNER_ID_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_req_ff.cmd             <= req_if.cmd;
         in_req_ff.value           <= req_if.value;
         in_req_ff.caller_pid      <= req_if.caller_pid;
         in_req_ff.caller_tid      <= req_if.caller_tid;
         in_req_ff.waiters_present <= req_if.waiters_present;
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.status       = out_rsp_ff.status;
   assign rsp_if.result_value = out_rsp_ff.result_value;
   assign rsp_if.readable     = out_rsp_ff.readable;
   assign rsp_if.error_flag   = out_rsp_ff.error_flag;
   assign rsp_if.wake_kind    = out_rsp_ff.wake_kind;

endmodule
